### hw/rtl/sfla_pkg.sv
// sfla_pkg: shared types and constants of the segregated free list allocator
// depends on nothing; imported by sfla_size_class and the top level
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

  localparam int unsigned CLS_W     = 7;   // class number, up to 128 classes
  localparam int unsigned CBYTES_W  = 31;  // class size in bytes, up to 2^30
  localparam int unsigned SIZE_W    = 31;
  localparam int unsigned STEP_BYTES = 16;
  localparam int unsigned HDR_BYTES  = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_MEM   = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_END   = 1'b1;

  // result of the size to class mapping
  typedef struct packed {
    logic [CLS_W-1:0]    cls;
    logic [CBYTES_W-1:0] class_bytes;
    logic                big;
  } sfla_class_t;

endpackage

`default_nettype wire

### hw/rtl/sfla_size_class.sv
// sfla_size_class: maps a request size to its size class
// depends on sfla_pkg; big classes are found by a shift-compare loop
`timescale 1ns / 1ps
`default_nettype none

module sfla_size_class #(
  parameter int unsigned SMALL_CLASSES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sfla_pkg::SIZE_W-1:0] size,
  output logic                           done,
  output sfla_pkg::sfla_class_t          result
);
  import sfla_pkg::*;

  localparam logic [CBYTES_W-1:0] SMALL_LIMIT = CBYTES_W'(SMALL_CLASSES * STEP_BYTES);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [CBYTES_W-1:0]  cb_r, cb_nxt;
  logic [CLS_W-1:0]     idx_r, idx_nxt;
  sfla_class_t          res_r, res_nxt;
  logic [SIZE_W-1:0]    size_m1;

  assign size_m1 = size - SIZE_W'(1);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    size_nxt = size_r;
    cb_nxt   = cb_r;
    idx_nxt  = idx_r;
    res_nxt  = res_r;
    if (start) begin
      if (size <= SIZE_W'(SMALL_LIMIT)) begin
        // 16-byte steps
        res_nxt.cls         = CLS_W'(size_m1 >> 4);
        res_nxt.class_bytes = CBYTES_W'((size_m1 >> 4) + SIZE_W'(1)) << 4;
        res_nxt.big         = 1'b0;
        done_nxt            = 1'b1;
      end else begin
        run_nxt  = 1'b1;
        size_nxt = size;
        cb_nxt   = SMALL_LIMIT << 1;
        idx_nxt  = '0;
      end
    end else if (run_r) begin
      if (SIZE_W'(cb_r) >= size_r) begin
        res_nxt.cls         = CLS_W'(SMALL_CLASSES) + idx_r;
        res_nxt.class_bytes = cb_r;
        res_nxt.big         = 1'b1;
        done_nxt            = 1'b1;
        run_nxt             = 1'b0;
      end else begin
        cb_nxt  = cb_r << 1;
        idx_nxt = idx_r + CLS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    size_r <= size_nxt;
    cb_r   <= cb_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

### hw/rtl/segregated_free_list_allocator_unit.sv
// segregated_free_list_allocator_unit: top level of the size class allocator
// depends on sfla_pkg and sfla_size_class; holds class heads and header store
`timescale 1ns / 1ps
`default_nettype none

// One transaction at a time: a transaction is taken when start is high and busy
// is low, and its result shows on out_valid for exactly one cycle; the receiver
// cannot stall it. The class search of an alloc takes longer for big sizes, and
// an empty list is first refilled one carved block a cycle (up to SMALL_REFILL or
// BIG_REFILL). Bad sizes and unknown frees of bad alignment answer the cycle
// after the transaction. List links sit in a header store with registered reads
// and its own write port. After reset the header store is cleared one entry a
// cycle, all 2^(ARENA_ADDR_BITS-3) entries (8192 by default), with busy high;
// config writes still land meanwhile.

module segregated_free_list_allocator_unit #(
  parameter int unsigned ARENA_ADDR_BITS = 16,
  parameter int unsigned SMALL_CLASSES   = 64,
  parameter int unsigned BIG_CLASSES     = 20,
  parameter int unsigned SMALL_REFILL    = 8,
  parameter int unsigned BIG_REFILL      = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [30:0] in_request_size,
  input  wire logic [15:0] in_block_address,
  output logic             out_valid,
  output logic [15:0]      out_result_address,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_wdata
);
  import sfla_pkg::*;

  localparam int unsigned AW    = ARENA_ADDR_BITS;
  localparam int unsigned LW    = AW + 1;             // link, with the none code
  localparam int unsigned SW    = AW - 3;             // header slot index
  localparam int unsigned BW    = (LW > 17) ? LW : 17; // bump pointer
  localparam int unsigned NCLS  = SMALL_CLASSES + BIG_CLASSES;
  localparam int unsigned CIW   = $clog2(NCLS);
  localparam int unsigned EW    = CLS_W + LW;          // tag and next link
  localparam int unsigned DEPTH = 1 << SW;
  localparam logic [LW-1:0] LINK_NONE = LW'(1) << AW;
  localparam logic [32:0] ARENA_SPAN  = 33'(1) << AW;
  localparam logic [31:0] MAX_REQUEST = 32'(SMALL_CLASSES * STEP_BYTES) << BIG_CLASSES;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CLASS, S_HWAIT, S_HREAD, S_CARVE,
    S_POPRD, S_POP, S_FRD, S_FTAG, S_FWAIT, S_FPUSH
  } state_t;

  state_t              state_r;
  logic [SW-1:0]       clr_idx_r;
  logic [16:0]         heap_end_r;
  logic [BW-1:0]       bump_r;
  logic [CIW-1:0]      cls_r;
  logic [CBYTES_W-1:0] cb_r;
  logic                big_r;
  logic [4:0]          cnt_r;
  logic [LW-1:0]       cur_r;
  logic [SW-1:0]       slot_r;
  logic [CLS_W-1:0]    tag_r;
  logic                out_valid_r;
  logic [15:0]         out_addr_r;
  logic [1:0]          out_status_r;

  // class heads with a valid bit each; invalid reads as an empty list
  logic [LW-1:0]   heads_mem [NCLS];
  logic [NCLS-1:0] heads_vld_r;
  logic [LW-1:0]   head_q;
  logic            head_vld_q;
  logic            heads_we;
  logic [LW-1:0]   heads_wdata;

  // header store: one entry per 8-byte offset
  logic [EW-1:0] hdr_mem [DEPTH];
  logic [EW-1:0] hdr_q;
  logic          hdr_we;
  logic [SW-1:0] hdr_waddr, hdr_raddr;
  logic [EW-1:0] hdr_wdata;

  sfla_class_t   cls_res;
  logic          cls_done;
  logic          cls_start;

  logic          accept;
  logic [32:0]   lim, carve_end;
  logic [LW-1:0] cur_head;
  logic [31:0]   cur_ext, fhdr;
  logic [4:0]    refill_cnt;
  logic [CLS_W-1:0] q_tag;
  logic [LW-1:0]    q_next;
  logic [16:0]      bump_cfg;

  assign accept    = start && !busy;
  assign cls_start = accept && (in_func == FUNC_ALLOC) && (in_request_size != '0)
                     && (32'(in_request_size) <= MAX_REQUEST);

  sfla_size_class #(.SMALL_CLASSES(SMALL_CLASSES)) u_size_class (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cls_start),
    .size   (in_request_size),
    .done   (cls_done),
    .result (cls_res)
  );

  // arena limit and carve end for the block at the bump pointer
  assign lim = (33'(heap_end_r) > ARENA_SPAN) ? ARENA_SPAN : 33'(heap_end_r);
  assign carve_end  = 33'(bump_r) + 33'(HDR_BYTES) + 33'(cb_r);
  assign cur_head   = head_vld_q ? head_q : LINK_NONE;
  assign cur_ext    = 32'(cur_r);
  assign fhdr       = 32'(in_block_address) - 32'(HDR_BYTES);
  assign refill_cnt = big_r ? 5'(BIG_REFILL) : 5'(SMALL_REFILL);
  assign q_tag      = hdr_q[EW-1:LW];
  assign q_next     = hdr_q[LW-1:0];
  assign bump_cfg   = (17'(cfg_wdata[15:0]) + 17'd7) & ~17'd7;

  // memory port control
  always_comb begin
    hdr_we      = 1'b0;
    hdr_waddr   = cur_ext[SW+2:3];
    hdr_wdata   = {tag_r, LINK_NONE};
    hdr_raddr   = (state_r == S_POPRD) ? cur_ext[SW+2:3] : slot_r;
    heads_we    = 1'b0;
    heads_wdata = cur_r;
    case (state_r)
      S_CLEAR: begin
        hdr_we    = 1'b1;
        hdr_waddr = clr_idx_r;
        hdr_wdata = {CLS_W'(0), LINK_NONE};
      end
      S_CARVE: begin
        if (carve_end > lim) begin
          // keep what was carved before running out
          heads_we = (cnt_r != '0);
        end else begin
          hdr_we    = 1'b1;
          hdr_waddr = bump_r[SW+2:3];
          hdr_wdata = {CLS_W'(cls_r) + CLS_W'(1), cur_r};
        end
      end
      S_POP: begin
        hdr_we      = 1'b1;
        hdr_wdata   = {q_tag, LINK_NONE};
        heads_we    = 1'b1;
        heads_wdata = q_next;
      end
      S_FPUSH: begin
        hdr_we      = 1'b1;
        hdr_waddr   = slot_r;
        hdr_wdata   = {tag_r, cur_head};
        heads_we    = 1'b1;
        heads_wdata = LW'(slot_r) << 3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
    hdr_q <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[cls_r] <= heads_wdata;
    head_q     <= heads_mem[cls_r];
    head_vld_q <= heads_vld_r[cls_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      heap_end_r   <= 17'd65536;
      bump_r       <= BW'(8);
      heads_vld_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (heads_we) heads_vld_r[cls_r] <= 1'b1;
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + SW'(1);
          if (clr_idx_r == SW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            out_addr_r <= '0;
            if (in_func == FUNC_ALLOC) begin
              if (cls_start) begin
                state_r <= S_CLASS;
              end else begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_BAD_SIZE;
              end
            end else if (in_block_address < 16'(HDR_BYTES) ||
                         in_block_address[2:0] != 3'd0 ||
                         33'(fhdr) >= ARENA_SPAN) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_IGNORED;
            end else begin
              slot_r  <= fhdr[SW+2:3];
              state_r <= S_FRD;
            end
          end
        end
        S_CLASS: begin
          if (cls_done) begin
            cls_r   <= CIW'(cls_res.cls);
            cb_r    <= cls_res.class_bytes;
            big_r   <= cls_res.big;
            state_r <= S_HWAIT;
          end
        end
        S_HWAIT: state_r <= S_HREAD;
        S_HREAD: begin
          cur_r <= cur_head;
          cnt_r <= '0;
          state_r <= (cur_head == LINK_NONE) ? S_CARVE : S_POPRD;
        end
        S_CARVE: begin
          if (carve_end > lim) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_NO_MEM;
            state_r      <= S_IDLE;
          end else begin
            cur_r  <= LW'(bump_r);
            bump_r <= BW'(carve_end);
            cnt_r  <= cnt_r + 5'd1;
            if (cnt_r + 5'd1 == refill_cnt) state_r <= S_POPRD;
          end
        end
        S_POPRD: state_r <= S_POP;
        S_POP: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_addr_r   <= 16'(cur_ext + 32'(HDR_BYTES));
          state_r      <= S_IDLE;
        end
        S_FRD: state_r <= S_FTAG;
        S_FTAG: begin
          if (q_tag == '0 || q_tag > CLS_W'(NCLS)) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_IGNORED;
            state_r      <= S_IDLE;
          end else begin
            tag_r   <= q_tag;
            cls_r   <= CIW'(q_tag - CLS_W'(1));
            state_r <= S_FWAIT;
          end
        end
        S_FWAIT: state_r <= S_FPUSH;
        S_FPUSH: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // config writes land in any state; heap_start only reloads the bump pointer
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_START) begin
          bump_r <= BW'(bump_cfg);
        end else begin
          heap_end_r <= cfg_wdata;
        end
      end
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

### verif/sfla_checker.sv
// sfla_checker: watches the transaction and config ports of the allocator,
// predicts each result and compares it; depends on sfla_pkg
`timescale 1ns / 1ps

module sfla_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_func,
  input  wire logic [30:0] in_request_size,
  input  wire logic [15:0] in_block_address,
  input  wire logic        out_valid,
  input  wire logic [15:0] out_result_address,
  input  wire logic [1:0]  out_status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_wdata,
  output int               mismatches,
  output int               outstanding
);
  import sfla_pkg::*;

  localparam int SLOTS = 8192;
  localparam int NCLS  = 84;
  localparam logic [16:0] NO_LINK = 17'h10000;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } alloc_result_t;

  logic [6:0]    hdr_tag  [SLOTS];   // 0 = no class, else class + 1
  logic [16:0]   hdr_link [SLOTS];
  logic [16:0]   list_head[NCLS];
  logic [16:0]   bump;
  logic [16:0]   heap_end_q;
  logic [15:0]   heap_start_q;
  alloc_result_t pending_results[$];
  int            errs;

  task automatic predict_alloc(input logic [30:0] size, output alloc_result_t r);
    int          cls;
    int          cnt;
    longint      cbytes;
    longint      blk;
    longint      lim;
    logic [16:0] h;
    r = '{16'd0, ST_OK};
    if (size == 0 || size > 31'h4000_0000) begin
      r.status = ST_BAD_SIZE;
      return;
    end
    if (size <= 1024) begin
      cls    = (int'(size) - 1) / 16;
      cbytes = (cls + 1) * 16;
      cnt    = 8;
    end else begin
      cbytes = 2048;
      cls    = 64;
      while (cbytes < size) begin
        cbytes = cbytes << 1;
        cls++;
      end
      cnt = 4;
    end
    if (list_head[cls] == NO_LINK) begin
      // carve from the bump pointer; partial carves stay on the list
      blk = 16 + cbytes;
      lim = (heap_end_q > 17'h10000) ? 65536 : longint'(heap_end_q);
      for (int i = 0; i < cnt; i++) begin
        if (longint'(bump) + blk > lim) begin
          r.status = ST_NO_MEM;
          return;
        end
        hdr_tag[bump[15:3]]  = 7'(cls + 1);
        hdr_link[bump[15:3]] = list_head[cls];
        list_head[cls]       = bump;
        bump                 = 17'(longint'(bump) + blk);
      end
    end
    h                  = list_head[cls];
    list_head[cls]     = hdr_link[h[15:3]];
    hdr_link[h[15:3]]  = NO_LINK;
    r.addr             = h[15:0] + 16'd16;
  endtask

  task automatic predict_free(input logic [15:0] addr, output alloc_result_t r);
    logic [15:0] hdr;
    logic [6:0]  t;
    r = '{16'd0, ST_IGNORED};
    if (addr < 16 || addr[2:0] != 3'd0) return;
    hdr = addr - 16'd16;
    t   = hdr_tag[hdr[15:3]];
    if (t == 0 || t > NCLS) return;
    hdr_link[hdr[15:3]] = list_head[t - 1];
    list_head[t - 1]    = {1'b0, hdr};
    r.status = ST_OK;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        hdr_tag[i]  = '0;
        hdr_link[i] = NO_LINK;
      end
      for (int i = 0; i < NCLS; i++) list_head[i] = NO_LINK;
      heap_start_q = 16'd8;
      heap_end_q   = 17'h10000;
      bump         = 17'd8;
      pending_results.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_START) begin
          heap_start_q = cfg_wdata[15:0];
          bump = ({1'b0, heap_start_q} + 17'd7) & ~17'd7;
        end else begin
          heap_end_q = cfg_wdata;
        end
      end
      if (out_valid) begin
        got = '{out_result_address, out_status};
        if (pending_results.size() == 0) begin
          errs++;
          $display("%0t unexpected result: expected none, got addr %h status %0d",
                   $time, got.addr, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.addr !== want.addr || got.status !== want.status) begin
            errs++;
            $display("%0t mismatch: expected addr %h status %0d, got addr %h status %0d",
                     $time, want.addr, want.status, got.addr, got.status);
          end
        end
      end
      if (start && !busy) begin
        if (in_func == FUNC_ALLOC) predict_alloc(in_request_size, want);
        else predict_free(in_block_address, want);
        pending_results.push_back(want);
      end
    end
    mismatches  <= errs;
    outstanding <= pending_results.size();
  end

endmodule

### verif/segregated_free_list_allocator_unit_test.sv
// segregated_free_list_allocator_unit_test: stimulus and verdict for the allocator
// depends on sfla_pkg, the allocator top level and sfla_checker
`timescale 1ns / 1ps

module segregated_free_list_allocator_unit_test;
  import sfla_pkg::*;

  localparam int STALL_LIMIT = 30000;  // covers the header store clearing pass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [30:0] in_request_size;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic [15:0] out_result_address;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_wdata;
  int          mismatches;
  int          outstanding;
  int          quiet_cycles;
  int          gap_pct;
  logic [15:0] live_blocks[$];  // payload offsets handed out, candidates for free

  segregated_free_list_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_request_size(in_request_size),
    .in_block_address(in_block_address), .out_valid(out_valid),
    .out_result_address(out_result_address), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sfla_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_request_size(in_request_size),
    .in_block_address(in_block_address), .out_valid(out_valid),
    .out_result_address(out_result_address), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // remember granted blocks so that later frees hit real headers
  always @(posedge clk) begin
    if (out_valid && out_status == ST_OK && out_result_address != 16'd0) begin
      live_blocks.push_back(out_result_address);
      if (live_blocks.size() > 200) void'(live_blocks.pop_front());
    end
  end

  // watchdog: no transaction in or out for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("segregated_free_list_allocator_unit_test: FAIL");
        $finish;
      end
    end
  end

  // present one transaction and hold it until the block takes it
  task automatic send(input logic f, input logic [30:0] size, input logic [15:0] addr);
    start            <= 1'b1;
    in_func          <= f;
    in_request_size  <= size;
    in_block_address <= addr;
    do @(posedge clk); while (busy);
    // random sender gap after the transaction
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drain everything in flight, then pause with start low
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one write cycle, then the enable goes low again before the task returns
  task automatic write_cfg(input logic idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_live(input bit keep);
    int k;
    if (live_blocks.size() == 0) begin
      send(FUNC_FREE, 31'($urandom), 16'($urandom));
    end else begin
      k = $urandom_range(live_blocks.size() - 1);
      send(FUNC_FREE, 31'($urandom), live_blocks[k]);
      if (!keep) live_blocks.delete(k);
    end
  endtask

  // mostly well-formed alloc/free traffic, the rest noise
  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      send(FUNC_ALLOC, 31'($urandom_range(1, 1024)), 16'($urandom));
    end else if (r < 55) begin
      send(FUNC_ALLOC, 31'($urandom_range(1025, ($urandom_range(3) == 0) ? 65536 : 8192)),
           16'($urandom));
    end else if (r < 62) begin
      case ($urandom_range(3))
        0: send(FUNC_ALLOC, 31'd0, 16'($urandom));
        1: send(FUNC_ALLOC, 31'($urandom), 16'($urandom));
        2: send(FUNC_ALLOC, 31'h4000_0000 + 31'($urandom_range(0, 1)), 16'($urandom));
        default: send(FUNC_ALLOC, 31'h7fff_ffff, 16'hffff);
      endcase
    end else if (r < 92) begin
      free_live($urandom_range(9) == 0);  // occasional double free
    end else begin
      send(FUNC_FREE, 31'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] starts[5];
    logic [16:0] ends[5];
    int          counts[5];
    starts = '{16'd8,     16'd4099,  16'd8,    16'd65528, 16'd1000};
    ends   = '{17'h10000, 17'd40000, 17'd200,  17'd16,    17'h10000};
    counts = '{400,       350,       100,      50,        300};

    rst_n            = 1'b0;
    start            = 1'b0;
    in_func          = FUNC_ALLOC;
    in_request_size  = '0;
    in_block_address = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_HEAP_START;
    cfg_wdata        = '0;
    gap_pct          = 23;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size extremes, class boundaries, every kind of ignored free
    send(FUNC_ALLOC, 31'd0, 16'd0);
    send(FUNC_ALLOC, 31'h4000_0001, 16'd0);
    send(FUNC_ALLOC, 31'h7fff_ffff, 16'hffff);
    send(FUNC_ALLOC, 31'd1, 16'd0);
    send(FUNC_ALLOC, 31'd16, 16'd0);
    send(FUNC_ALLOC, 31'd17, 16'd0);
    send(FUNC_ALLOC, 31'd1024, 16'd0);
    send(FUNC_ALLOC, 31'd1025, 16'd0);
    send(FUNC_ALLOC, 31'd2048, 16'd0);
    send(FUNC_ALLOC, 31'd2049, 16'd0);
    send(FUNC_ALLOC, 31'h4000_0000, 16'd0);  // out of memory
    send(FUNC_FREE, 31'h7fff_ffff, 16'd0);  // null
    send(FUNC_FREE, 31'd0, 16'd8);          // below the header size
    send(FUNC_FREE, 31'd0, 16'd20);         // misaligned
    send(FUNC_FREE, 31'd0, 16'hfff8);       // never carved
    wait_idle();
    free_live(1'b1);                        // free one block but keep it listed, so it may be freed again
    free_live(1'b0);
    send(FUNC_ALLOC, 31'd1, 16'd0);
    send(FUNC_ALLOC, 31'd1, 16'd0);

    // random phases, each with its own arena bounds
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_cfg(CFG_HEAP_START, {1'b0, starts[p]});
      write_cfg(CFG_HEAP_END, ends[p]);
      gap_pct = (p == 0) ? 23 : (p == 1) ? 87 : 0;
      for (int i = 0; i < counts[p]; i++) random_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("segregated_free_list_allocator_unit_test: PASS");
    end else begin
      $display("segregated_free_list_allocator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
